// File: rtl/yeje_pkg.sv
// Shared types, constants and a helper function of the YAML-to-JSON escape translator.
`timescale 1ns / 1ps
`default_nettype none

package yeje_pkg;

  // Default depth of the command queue between front and back end.
  localparam int unsigned FIFO_DEPTH_DEF = 4;

  // Characters that the translator recognizes or produces.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_E   = 8'h65;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_UC_N   = 8'h4E;
  localparam logic [7:0] CH_UC_L   = 8'h4C;
  localparam logic [7:0] CH_UC_P   = 8'h50;
  localparam logic [7:0] CH_UC_U   = 8'h55;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam logic [7:0] BYTE_BEL  = 8'h07;
  localparam logic [7:0] BYTE_ESC  = 8'h1B;

  // High surrogate and low surrogate prefixes (top six bits).
  localparam logic [5:0] SURR_HI_TAG = 6'b110110;
  localparam logic [5:0] SURR_LO_TAG = 6'b110111;

  localparam logic [7:0] HEX_UPPER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2
  } scan_mode_e;

  typedef enum logic [1:0] {
    CMD_LIT   = 2'd0,  // one to three literal bytes
    CMD_UESC  = 2'd1,  // one or two \uXXXX escapes
    CMD_FLUSH = 2'd2   // "\U", collected digits, optional tail byte
  } cmd_kind_e;

  // One unit of work for the back end: it expands into len output bytes.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [3:0]  len;
    logic [63:0] data;
    logic [7:0]  tail;
    logic        has_tail;
    logic        last;
  } cmd_t;

  // Returns {valid, value} for an ASCII hex digit of either case.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/yeje_front.sv
// Front end: scans input bytes, tracks escape state and issues output commands.
`timescale 1ns / 1ps
`default_nettype none

module yeje_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output      logic          s_axis_tready,
  input  wire logic [7:0]    s_axis_tdata,   // [7:0] in_byte
  input  wire logic          s_axis_tlast,   // in_last
  input  wire logic          full_i,
  output      logic          push_o,
  output      yeje_pkg::cmd_t cmd_o
);
  import yeje_pkg::*;

  scan_mode_e  mode_q, mode_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [27:0] code_q, code_d;
  logic [7:0]  digits_q [8];
  logic [7:0]  dig_new  [8];
  logic [63:0] dig_old_packed, dig_new_packed;

  logic        accept;
  logic        wr_digit;
  logic [7:0]  b;
  logic        last;
  logic [4:0]  hx;
  logic [31:0] cp;
  logic [4:0]  plane;
  logic [19:0] cp_off;
  cmd_t        cmd;

  assign b      = s_axis_tdata;
  assign last   = s_axis_tlast;
  assign hx     = hex_decode(b);
  assign cp     = {code_q, hx[3:0]};
  assign plane  = cp[20:16] - 5'd1;
  assign cp_off = {plane[3:0], cp[15:0]};

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      dig_new[k] = digits_q[k];
    end
    dig_new[cnt_q] = b;
    for (int k = 0; k < 8; k++) begin
      dig_old_packed[k*8 +: 8] = digits_q[k];
      dig_new_packed[k*8 +: 8] = dig_new[k];
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.kind     = CMD_LIT;
    cmd.tail     = b;
    cmd.last     = last;
    mode_d       = mode_q;
    cnt_d        = cnt_q;
    code_d       = code_q;
    wr_digit     = 1'b0;

    unique case (mode_q)
      MODE_ESC: begin
        mode_d = MODE_PLAIN;
        cmd.len = 4'd1;
        case (b)
          CH_ZERO:  cmd.data[7:0] = 8'h00;
          CH_LC_A:  cmd.data[7:0] = BYTE_BEL;
          CH_LC_E:  cmd.data[7:0] = BYTE_ESC;
          CH_SPACE: cmd.data[7:0] = CH_SPACE;
          CH_UC_N: begin
            cmd.len        = 4'd2;
            cmd.data[15:0] = 16'h85C2;
          end
          CH_UNDER: begin
            cmd.len        = 4'd2;
            cmd.data[15:0] = 16'hA0C2;
          end
          CH_UC_L: begin
            cmd.len        = 4'd3;
            cmd.data[23:0] = 24'hA880E2;
          end
          CH_UC_P: begin
            cmd.len        = 4'd3;
            cmd.data[23:0] = 24'hA980E2;
          end
          CH_UC_U: begin
            // An escape that ends the scalar right after \U flushes as written.
            cnt_d  = 3'd0;
            code_d = '0;
            if (last) begin
              cmd.kind = CMD_FLUSH;
              cmd.len  = 4'd2;
            end else begin
              cmd.len = 4'd0;
              mode_d  = MODE_HEX;
            end
          end
          default: begin
            cmd.len        = 4'd2;
            cmd.data[15:0] = {b, CH_BSLASH};
          end
        endcase
      end

      MODE_HEX: begin
        if (hx[4]) begin
          wr_digit = 1'b1;
          if (cnt_q == 3'd7) begin
            mode_d = MODE_PLAIN;
            cnt_d  = 3'd0;
            code_d = '0;
            if (cp[31:16] == 16'd0) begin
              cmd.kind       = CMD_UESC;
              cmd.len        = 4'd6;
              cmd.data[15:0] = cp[15:0];
            end else if (cp[31:21] != 11'd0 || cp[20:16] > 5'h10) begin
              cmd.kind = CMD_FLUSH;
              cmd.len  = 4'd10;
              cmd.data = dig_new_packed;
            end else begin
              cmd.kind        = CMD_UESC;
              cmd.len         = 4'd12;
              cmd.data[15:0]  = {SURR_HI_TAG, cp_off[19:10]};
              cmd.data[31:16] = {SURR_LO_TAG, cp_off[9:0]};
            end
          end else if (last) begin
            mode_d   = MODE_PLAIN;
            cnt_d    = 3'd0;
            code_d   = '0;
            cmd.kind = CMD_FLUSH;
            cmd.len  = 4'd3 + {1'b0, cnt_q};
            cmd.data = dig_new_packed;
          end else begin
            cnt_d   = cnt_q + 3'd1;
            code_d  = cp[27:0];
            cmd.len = 4'd0;
          end
        end else begin
          // A non-hex byte ends the sequence and is then scanned as plain text.
          cnt_d        = 3'd0;
          code_d       = '0;
          cmd.kind     = CMD_FLUSH;
          cmd.data     = dig_old_packed;
          cmd.has_tail = (b != CH_BSLASH) || last;
          cmd.len      = 4'd2 + {1'b0, cnt_q} + {3'd0, cmd.has_tail};
          mode_d       = (b == CH_BSLASH && !last) ? MODE_ESC : MODE_PLAIN;
        end
      end

      default: begin
        mode_d        = (b == CH_BSLASH && !last) ? MODE_ESC : MODE_PLAIN;
        cmd.len       = (b != CH_BSLASH || last) ? 4'd1 : 4'd0;
        cmd.data[7:0] = b;
      end
    endcase
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.len != 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      cnt_q  <= 3'd0;
      code_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      code_q <= code_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && wr_digit) begin
      digits_q[cnt_q] <= b;
    end
  end

endmodule

`default_nettype wire

// File: rtl/yeje_fifo.sv
// Command queue between the scanning front end and the expanding back end.
`timescale 1ns / 1ps
`default_nettype none

module yeje_fifo #(
  parameter int unsigned DEPTH = yeje_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire yeje_pkg::cmd_t wdata_i,
  output      logic           full_o,
  input  wire logic           pop_i,
  output      logic           valid_o,
  output      yeje_pkg::cmd_t rdata_o
);
  import yeje_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/yeje_back.sv
// Back end: expands one queued command into output bytes, one byte per cycle unless the receiver stalls.
`timescale 1ns / 1ps
`default_nettype none

module yeje_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           head_valid_i,
  input  wire yeje_pkg::cmd_t head_i,
  output      logic           pop_o,
  output      logic           m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output      logic [7:0]     m_axis_tdata,   // [7:0] out_byte
  output      logic           m_axis_tlast    // out_last
);
  import yeje_pkg::*;

  logic [3:0]  idx_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;

  logic        out_free, fire, at_end, second;
  logic [2:0]  sub, didx;
  logic [15:0] word;
  logic [7:0]  sel;

  assign out_free = !out_valid_q || m_axis_tready;
  assign fire     = head_valid_i && out_free;
  assign at_end   = (idx_q == head_i.len - 4'd1);
  assign pop_o    = fire && at_end;

  // For \u escapes, the second escape of a surrogate pair starts at byte six.
  assign second = (idx_q >= 4'd6);
  assign sub    = second ? 3'(idx_q - 4'd6) : idx_q[2:0];
  assign word   = second ? head_i.data[31:16] : head_i.data[15:0];
  assign didx   = 3'(idx_q - 4'd2);

  always_comb begin
    sel = CH_BSLASH;
    unique case (head_i.kind)
      CMD_UESC: begin
        case (sub)
          3'd1:    sel = CH_LC_U;
          3'd2:    sel = HEX_UPPER[word[15:12]];
          3'd3:    sel = HEX_UPPER[word[11:8]];
          3'd4:    sel = HEX_UPPER[word[7:4]];
          3'd5:    sel = HEX_UPPER[word[3:0]];
          default: sel = CH_BSLASH;
        endcase
      end
      CMD_FLUSH: begin
        if (idx_q == 4'd0) begin
          sel = CH_BSLASH;
        end else if (idx_q == 4'd1) begin
          sel = CH_UC_U;
        end else if (head_i.has_tail && at_end) begin
          sel = head_i.tail;
        end else begin
          sel = head_i.data[{didx, 3'b000} +: 8];
        end
      end
      CMD_LIT: begin
        case (idx_q[1:0])
          2'd0:    sel = head_i.data[7:0];
          2'd1:    sel = head_i.data[15:8];
          default: sel = head_i.data[23:16];
        endcase
      end
      default: sel = CH_BSLASH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        idx_q       <= at_end ? 4'd0 : idx_q + 4'd1;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q <= sel;
      out_last_q <= head_i.last && at_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: rtl/yaml_escape_to_json_escape_unit.sv
// Top level of the YAML-to-JSON escape translator: front end, command queue, back end.
//
//   Channel   Direction  Payload                       Framing
//   s_axis    in         tdata[7:0] = in_byte          tlast = in_last
//   m_axis    out        tdata[7:0] = out_byte         tlast = out_last
//
// The front end takes one byte per cycle while the queue is not full and turns each
// byte into at most one command. The back end emits one output byte per cycle unless
// the receiver stalls; an escape expands into up to twelve bytes, so the back end sets
// the sustained rate. Each command is queued, and each output byte is registered.
// The queue holds FIFO_DEPTH commands; s_axis_tready falls only while it is full.
// Reset is asynchronous and returns the scanner to plain text with an empty queue.
`timescale 1ns / 1ps
`default_nettype none

module yaml_escape_to_json_escape_unit #(
  parameter int unsigned FIFO_DEPTH = yeje_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output      logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,   // in_last
  output      logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output      logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output      logic       m_axis_tlast    // out_last
);
  import yeje_pkg::*;

  logic push, full, pop, head_valid;
  cmd_t cmd, head;

  yeje_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (cmd)
  );

  yeje_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rdata_o (head)
  );

  yeje_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: rtl/yeje_checker.sv
// Port-level checker for the escape translator, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module yeje_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [7:0] s_axis_tdata,
  input wire logic       s_axis_tlast,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  logic       s_acc, m_acc;
  logic [7:0] open_q;
  logic       seen_q;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  // Scalars whose final request has been accepted but whose final byte is still due.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 8'd0;
      seen_q <= 1'b0;
    end else begin
      if (s_acc) seen_q <= 1'b1;
      if ((s_acc && s_axis_tlast) && !(m_acc && m_axis_tlast)) begin
        open_q <= open_q + 8'd1;
      end else if (!(s_acc && s_axis_tlast) && (m_acc && m_axis_tlast)) begin
        open_q <= open_q - 8'd1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_last_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc && m_axis_tlast |-> open_q != 8'd0)
    else $error("scalar end emitted before its final input byte");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> seen_q)
    else $error("output byte without any accepted input");

  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind yaml_escape_to_json_escape_unit yeje_checker u_yeje_checker (.*);

`default_nettype wire

// File: verif/yaml_escape_to_json_escape_unit_tb.sv
// Self-checking testbench of the YAML-to-JSON escape translator, driven over its stream ports.
`timescale 1ns / 1ps

module yaml_escape_to_json_escape_unit_tb;
  import yeje_pkg::*;

  localparam int unsigned N_RANDOM_ITEMS = 354;
  localparam int unsigned HOLD_CYCLES    = 200;
  // Longest quiet stretch in a correct run is the receiver hold-off; the rest are short gaps.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned MAX_REPORTS    = 10;

  localparam logic [31:0] CP_BMP_MAX   = 32'h0000_FFFF;
  localparam logic [31:0] CP_MAX       = 32'h0010_FFFF;
  localparam logic [31:0] CP_SUPP_BASE = 32'h0001_0000;
  localparam logic [15:0] SURR_HI_BASE = 16'hD800;
  localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
  localparam logic [7:0]  CH_UC_A      = 8'h41;

  localparam logic [7:0] ESC_LETTERS [9] = '{
    CH_ZERO, CH_LC_A, CH_LC_E, CH_SPACE, CH_UC_N, CH_UNDER, CH_UC_L, CH_UC_P, CH_BSLASH
  };
  localparam logic [31:0] EDGE_CODES [8] = '{
    32'h0, 32'hFFFF, 32'h10000, 32'h10FFFF, 32'h110000, 32'hFFFFFFFF, 32'hD800, 32'hDFFF
  };

  typedef struct packed {
    logic [7:0] octet;
    logic       eos;
  } beat_t;

  // A directed row either carries its expected bytes (want, lowest byte first) or
  // leaves them to the translation model.
  typedef struct packed {
    logic [7:0]  octet;
    logic        eos;
    logic        typed;
    logic [1:0]  n;
    logic [23:0] want;
  } dir_row_t;

  localparam int unsigned N_DIR = 26;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{8'h00,     1'b0, 1'b1, 2'd1, 24'h000000},
    '{8'hFF,     1'b0, 1'b1, 2'd1, 24'h0000FF},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 24'h000000},
    '{CH_ZERO,   1'b0, 1'b1, 2'd1, 24'h000000},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 24'h000000},
    '{CH_LC_A,   1'b0, 1'b1, 2'd1, {16'h0, BYTE_BEL}},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 24'h000000},
    '{CH_LC_E,   1'b0, 1'b1, 2'd1, {16'h0, BYTE_ESC}},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 24'h000000},
    '{CH_SPACE,  1'b0, 1'b1, 2'd1, {16'h0, CH_SPACE}},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 24'h000000},
    '{CH_UC_N,   1'b0, 1'b1, 2'd2, {8'h00, 8'h85, 8'hC2}},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 24'h000000},
    '{CH_UNDER,  1'b0, 1'b1, 2'd2, {8'h00, 8'hA0, 8'hC2}},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 24'h000000},
    '{CH_UC_L,   1'b0, 1'b1, 2'd3, {8'hA8, 8'h80, 8'hE2}},
    '{CH_BSLASH, 1'b0, 1'b1, 2'd0, 24'h000000},
    '{CH_UC_P,   1'b1, 1'b1, 2'd3, {8'hA9, 8'h80, 8'hE2}},
    // A lone backslash on the final byte comes back as written.
    '{CH_BSLASH, 1'b1, 1'b1, 2'd1, {16'h0, CH_BSLASH}},
    // A \U sequence broken by 'g', which is then an ordinary byte.
    '{CH_BSLASH, 1'b0, 1'b0, 2'd0, 24'h000000},
    '{CH_UC_U,   1'b0, 1'b0, 2'd0, 24'h000000},
    '{8'h31,     1'b0, 1'b0, 2'd0, 24'h000000},
    '{8'h67,     1'b0, 1'b0, 2'd0, 24'h000000},
    // A \U sequence cut short by the end of the scalar.
    '{CH_BSLASH, 1'b0, 1'b0, 2'd0, 24'h000000},
    '{CH_UC_U,   1'b0, 1'b0, 2'd0, 24'h000000},
    '{8'h37,     1'b1, 1'b0, 2'd0, 24'h000000}
  };

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  yaml_escape_to_json_escape_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Scanner state of the translation model.
  scan_mode_e  scan_st   = MODE_PLAIN;
  int          ndig      = 0;
  logic [7:0]  digs [8];
  logic [31:0] code_acc  = '0;

  beat_t step_q [$];
  beat_t expected_bytes [$];
  beat_t stim_q [$];

  int  n_items     = 0;
  int  n_scalars   = 0;
  int  n_results   = 0;
  int  n_errors    = 0;
  int  burst_left  = 0;
  int  idle_cycles = 0;
  bit  hold_req    = 1'b0;

  function automatic int hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 4'd10) return CH_ZERO + 8'(nib);
    return (lower ? CH_LC_A : CH_UC_A) + 8'(nib) - 8'd10;
  endfunction

  task automatic put(input logic [7:0] b);
    step_q.push_back('{b, 1'b0});
  endtask

  task automatic put_u16(input logic [15:0] v);
    put(CH_BSLASH);
    put(CH_LC_U);
    for (int i = 3; i >= 0; i--) put(hex_char(v[4*i +: 4], 1'b0));
  endtask

  task automatic put_as_written(input int n);
    put(CH_BSLASH);
    put(CH_UC_U);
    for (int k = 0; k < n; k++) put(digs[k]);
  endtask

  task automatic plain_in(input logic [7:0] b);
    if (b == CH_BSLASH) scan_st = MODE_ESC;
    else put(b);
  endtask

  // Computes the bytes one accepted request produces into step_q.
  task automatic translate_byte(input logic [7:0] b, input logic eos);
    int          v;
    logic [31:0] cp;
    step_q.delete();
    if (scan_st == MODE_HEX) begin
      v = hex_value(b);
      if (v >= 0) begin
        digs[ndig[2:0]] = b;
        code_acc = {code_acc[27:0], 4'(v)};
        ndig++;
        if (ndig >= 8) begin
          if (code_acc <= CP_BMP_MAX) begin
            put_u16(code_acc[15:0]);
          end else if (code_acc > CP_MAX) begin
            put_as_written(8);
          end else begin
            cp = code_acc - CP_SUPP_BASE;
            put_u16(SURR_HI_BASE + 16'(cp[19:10]));
            put_u16(SURR_LO_BASE + 16'(cp[9:0]));
          end
          scan_st = MODE_PLAIN;
          ndig = 0;
          code_acc = '0;
        end
      end else begin
        put_as_written(ndig);
        scan_st = MODE_PLAIN;
        ndig = 0;
        code_acc = '0;
        plain_in(b);
      end
    end else if (scan_st == MODE_ESC) begin
      scan_st = MODE_PLAIN;
      case (b)
        CH_ZERO:  put(8'h00);
        CH_LC_A:  put(BYTE_BEL);
        CH_LC_E:  put(BYTE_ESC);
        CH_SPACE: put(CH_SPACE);
        CH_UC_N:  begin put(8'hC2); put(8'h85); end
        CH_UNDER: begin put(8'hC2); put(8'hA0); end
        CH_UC_L:  begin put(8'hE2); put(8'h80); put(8'hA8); end
        CH_UC_P:  begin put(8'hE2); put(8'h80); put(8'hA9); end
        CH_UC_U:  begin
          scan_st = MODE_HEX;
          ndig = 0;
          code_acc = '0;
        end
        default:  begin put(CH_BSLASH); put(b); end
      endcase
    end else begin
      plain_in(b);
    end
    if (eos) begin
      if (scan_st == MODE_ESC) put(CH_BSLASH);
      else if (scan_st == MODE_HEX) put_as_written(ndig);
      scan_st = MODE_PLAIN;
      ndig = 0;
      code_acc = '0;
    end
  endtask

  task automatic commit_step(input logic eos);
    if (eos && step_q.size() > 0) step_q[step_q.size() - 1].eos = 1'b1;
    foreach (step_q[k]) expected_bytes.push_back(step_q[k]);
  endtask

  // Offers one request, with the sender working in bursts separated by random gaps.
  task automatic offer(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_items++;
    if (eos) n_scalars++;
  endtask

  task automatic push_stim(input logic [7:0] b);
    stim_q.push_back('{b, $urandom_range(19) == 0});
  endtask

  // Random text: well-formed escapes with random content, some noise and broken \U.
  task automatic build_random_text();
    int          r;
    int          nd;
    logic [31:0] cv;
    logic [7:0]  b;
    while (stim_q.size() < N_RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 38) begin
        push_stim(8'($urandom_range(255)));
      end else if (r < 55) begin
        push_stim(CH_BSLASH);
        push_stim(ESC_LETTERS[$urandom_range(8)]);
      end else if (r < 63) begin
        push_stim(CH_BSLASH);
        push_stim(8'($urandom_range(255)));
      end else if (r < 86) begin
        case ($urandom_range(3))
          0:       cv = $urandom_range(32'hFFFF);
          1:       cv = CP_SUPP_BASE + $urandom_range(32'hFFFFF);
          2:       cv = 32'h110000 + $urandom_range(32'hFFEEFFFF);
          default: cv = EDGE_CODES[$urandom_range(7)];
        endcase
        push_stim(CH_BSLASH);
        push_stim(CH_UC_U);
        for (int i = 7; i >= 0; i--) push_stim(hex_char(cv[4*i +: 4], 1'($urandom_range(1))));
      end else begin
        nd = $urandom_range(7);
        push_stim(CH_BSLASH);
        push_stim(CH_UC_U);
        for (int i = 0; i < nd; i++) begin
          push_stim(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
        end
        do b = 8'($urandom_range(255)); while (hex_value(b) >= 0);
        push_stim(b);
      end
    end
  endtask

  task automatic report_error(input string what);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (expected_bytes.size() == 0) begin
        report_error($sformatf("unexpected byte %h last %b", m_axis_tdata, m_axis_tlast));
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata !== want.octet || m_axis_tlast !== want.eos) begin
          report_error($sformatf("byte %h last %b, expected byte %h last %b",
                                 m_axis_tdata, m_axis_tlast, want.octet, want.eos));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("yaml_escape_to_json_escape_unit: mismatch");
      $finish;
    end
  end

  // Receiver: a stall style that is redrawn at random, plus one long hold-off on request.
  initial begin
    int phase;
    int rx_style;
    phase = 0;
    rx_style = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      phase++;
      if (phase % 64 == 0) rx_style = $urandom_range(3);
      case (rx_style)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(1));
        2:       m_axis_tready <= (phase % 4 != 0);
        default: m_axis_tready <= ($urandom_range(3) == 0);
      endcase
    end
  end

  initial begin
    dir_row_t row;
    beat_t    item;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_ROWS[i];
      offer(row.octet, row.eos);
      translate_byte(row.octet, row.eos);
      if (row.typed) begin
        step_q.delete();
        for (int k = 0; k < row.n; k++) put(row.want[8*k +: 8]);
      end
      commit_step(row.eos);
    end

    build_random_text();
    // The receiver holds off while the sender keeps going, so the queue fills and
    // the input stalls.
    hold_req = 1'b1;
    for (int i = 0; i < stim_q.size(); i++) begin
      if (i == stim_q.size() / 2) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (expected_bytes.size() != 0);
        burst_left = 0;
      end
      item = stim_q[i];
      offer(item.octet, item.eos);
      translate_byte(item.octet, item.eos);
      commit_step(item.eos);
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (expected_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes in %0d closed scalars (all escape kinds, \\U values and breaks).",
             n_items, n_scalars);
    $display("Checked %0d output bytes, %0d errors.", n_results, n_errors);
    if (n_errors == 0 && expected_bytes.size() == 0) begin
      $display("yaml_escape_to_json_escape_unit: match");
    end else begin
      $display("yaml_escape_to_json_escape_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/yeje_pkg.sv
rtl/yeje_front.sv
rtl/yeje_fifo.sv
rtl/yeje_back.sv
rtl/yaml_escape_to_json_escape_unit.sv
rtl/yeje_checker.sv
verif/yaml_escape_to_json_escape_unit_tb.sv
